/* rtl/stack_machine_execute_top_assert.svh */
// Assertion macros for the stack machine execute block.
// Each check is sampled on clk and switched off while arst_n is low.
`ifndef STACK_MACHINE_EXECUTE_TOP_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_TOP_ASSERT_SVH

// Implication within the same cycle
`define SMX_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("smx assertion failed");

// Implication into the following cycle
`define SMX_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("smx assertion failed");

`endif

/* rtl/smx_pkg.sv */
// ----------------------------------------------------------------------------
// smx_pkg
// Shared opcodes, status codes and the divider request type.
// ----------------------------------------------------------------------------
`default_nettype none

package smx_pkg;

	localparam int DATA_W = 32;
	localparam int CMD_W  = 4;
	localparam int IN_W   = 72;   // cmd + immediate + in_value, byte aligned

	typedef enum logic [CMD_W-1:0] {
		CMD_IN   = 4'd0,
		CMD_OUT  = 4'd1,
		CMD_LIT  = 4'd2,
		CMD_DROP = 4'd3,
		CMD_DUP  = 4'd4,
		CMD_SWAP = 4'd5,
		CMD_ADD  = 4'd6,
		CMD_SUB  = 4'd7,
		CMD_MUL  = 4'd8,
		CMD_DIV  = 4'd9,
		CMD_MOD  = 4'd10,
		CMD_AND  = 4'd11,
		CMD_OR   = 4'd12,
		CMD_IFEQ = 4'd13,
		CMD_IFLT = 4'd14,
		CMD_JUMP = 4'd15
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2,
		ST_DIV0  = 2'd3
	} status_t;

	// Divider launch request
	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

endpackage

`default_nettype wire

/* rtl/smx_stack_ram.sv */
// ----------------------------------------------------------------------------
// smx_stack_ram
// Single-port data stack memory, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module smx_stack_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic                      we,
	input  wire logic [AW-1:0]             addr,
	input  wire logic [smx_pkg::DATA_W-1:0] wdata,
	output logic      [smx_pkg::DATA_W-1:0] rdata
);
	import smx_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];

	// write or registered read, one access per cycle
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/smx_div.sv */
// ----------------------------------------------------------------------------
// smx_div
// Signed 32-bit divider, one quotient bit per cycle, C truncation.
// ----------------------------------------------------------------------------
`default_nettype none

module smx_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire smx_pkg::div_req_t          req,
	output logic                            done,
	output logic      [smx_pkg::DATA_W-1:0] quot,
	output logic      [smx_pkg::DATA_W-1:0] rem
);
	import smx_pkg::*;

	logic              busy_q;
	logic [4:0]        step_q;
	logic              done_q;
	logic              qneg_q;
	logic              rneg_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dvs_q;
	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   diff;

	// trial subtract
	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath on magnitudes
	always_ff @(posedge clk) begin
		if (req.start) begin
			qneg_q <= req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
			rneg_q <= req.dividend[DATA_W-1];
			rem_q  <= '0;
			quo_q  <= req.dividend[DATA_W-1] ? -req.dividend : req.dividend;
			dvs_q  <= req.divisor[DATA_W-1] ? -req.divisor : req.divisor;
		end else if (busy_q) begin
			if (!diff[DATA_W]) begin
				rem_q <= diff[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	// sign fix
	assign done = done_q;
	assign quot = qneg_q ? -quo_q : quo_q;
	assign rem  = rneg_q ? -rem_q : rem_q;

endmodule

`default_nettype wire

/* rtl/stack_machine_execute_top.sv */
// ----------------------------------------------------------------------------
// stack_machine_execute_top
// Executes one stack-machine instruction per input transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one instruction per transaction (cmd, immediate,
//   in_value). Output stream m_*: exactly one result per instruction
//   (out_valid, out_value, next_pc, status), in order.
//   The input is ready only in the idle state, after the previous result
//   has been posted, so the block never takes a new instruction before
//   it is through with the last one. Faults go straight to posting. The
//   single-port stack RAM makes every operand read and every write a
//   separate step: binary operations read top and next, execute, then
//   write the result; DIV and MOD wait for the divider (one quotient bit
//   per cycle); DUP n reads and writes each of its m copies in turn.
//   Reset clears stack depth, program counter and the output valid flag;
//   stack RAM contents stay undefined. A stalled receiver holds the
//   result in the output register; the block finishes the next
//   instruction and waits before posting it.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_machine_execute_top #(
	parameter int STACK_DEPTH = 256,
	parameter int PROG_DEPTH  = 1024,
	localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
	localparam int CNT_W = $clog2(STACK_DEPTH + 1),
	localparam int PC_W  = $clog2(PROG_DEPTH + 1),
	localparam int MW    = ((35 + PC_W + 7) / 8) * 8
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	input  wire logic [smx_pkg::IN_W-1:0] s_tdata,  // cmd, immediate, in_value
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	output logic      [MW-1:0]           m_tdata   // out_valid, out_value, next_pc, status
);
	import smx_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_OUT, S_RDB, S_EXEC, S_DIV, S_WRR, S_WR2, S_DUPR, S_DUPW, S_DONE
	} state_t;

	localparam logic signed [32:0] JMAX = 33'(PROG_DEPTH + 1);

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PC_W-1:0]   pc_q;
	cmd_t              cmd_q;
	logic [PC_W-1:0]   jt_q;
	logic [PC_W-1:0]   npc_q;
	logic [DATA_W-1:0] a_q;
	logic [DATA_W-1:0] res_q;
	logic              ov_q;
	logic [DATA_W-1:0] oval_q;
	status_t           st_q;
	logic [AW-1:0]     src_q;
	logic [AW-1:0]     dst_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dupm_q;
	logic              m_valid_q;
	logic              mv_q;
	logic [DATA_W-1:0] mval_q;
	logic [PC_W-1:0]   mpc_q;
	status_t           mst_q;

	cmd_t              in_cmd;
	logic [DATA_W-1:0] in_imm;
	logic [DATA_W-1:0] in_val;
	logic              accept;
	logic [PC_W-1:0]   npc_inc;
	logic [PC_W-1:0]   jt;
	logic              dup_pos;
	logic [CNT_W-1:0]  dup_m;
	logic [CNT_W:0]    dup_sum;
	logic [CNT_W-1:0]  cnt_m1;
	logic [CNT_W-1:0]  cnt_m2;
	logic              full;
	logic              out_free;

	logic              ram_en;
	logic              ram_we;
	logic [AW-1:0]     ram_addr;
	logic [DATA_W-1:0] ram_wdata;
	logic [DATA_W-1:0] ram_rdata;

	div_req_t          div_req;
	logic              div_done;
	logic [DATA_W-1:0] div_quot;
	logic [DATA_W-1:0] div_rem;
	logic [DATA_W-1:0] alu;

	// input fields
	assign in_cmd   = cmd_t'(s_tdata[3:0]);
	assign in_imm   = s_tdata[35:4];
	assign in_val   = s_tdata[67:36];
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	// pc advance and jump target
	assign npc_inc = (pc_q == PC_W'(PROG_DEPTH)) ? pc_q : pc_q + 1'b1;
	always_comb begin
		priority if ($signed(in_imm) <= 32'sd1) begin
			jt = '0;
		end else if ($signed({in_imm[31], in_imm}) > JMAX) begin
			jt = PC_W'(PROG_DEPTH);
		end else begin
			jt = in_imm[PC_W-1:0] - 1'b1;
		end
	end

	// stack depth helpers
	assign cnt_m1  = cnt_q - 1'b1;
	assign cnt_m2  = cnt_q - CNT_W'(2);
	assign full    = (cnt_q == CNT_W'(STACK_DEPTH));
	assign dup_pos = !in_imm[31] && (in_imm != '0);
	assign dup_m   = ($signed({in_imm[31], in_imm}) > $signed(33'(cnt_q))) ?
		cnt_q : in_imm[CNT_W-1:0];
	assign dup_sum = {1'b0, cnt_q} + {1'b0, dup_m};

	// ALU on top (a_q) and next (RAM data)
	always_comb begin
		unique case (cmd_q)
			CMD_ADD: alu = a_q + ram_rdata;
			CMD_SUB: alu = a_q - ram_rdata;
			CMD_MUL: alu = a_q * ram_rdata;
			CMD_AND: alu = {{(DATA_W-1){1'b0}}, (a_q != '0) && (ram_rdata != '0)};
			CMD_OR:  alu = {{(DATA_W-1){1'b0}}, (a_q != '0) || (ram_rdata != '0)};
			default: alu = '0;
		endcase
	end

	// stack RAM port
	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = cnt_m1[AW-1:0];
		ram_wdata = res_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (in_cmd)
						CMD_IN, CMD_LIT: begin
							ram_en    = !full;
							ram_we    = 1'b1;
							ram_addr  = cnt_q[AW-1:0];
							ram_wdata = (in_cmd == CMD_IN) ? in_val : in_imm;
						end
						CMD_OUT:  ram_en = (cnt_q != '0);
						CMD_DROP, CMD_DUP, CMD_JUMP: ram_en = 1'b0;
						default:  ram_en = (cnt_q >= CNT_W'(2));
					endcase
				end
			end
			S_RDB: begin
				ram_en   = 1'b1;
				ram_addr = cnt_m2[AW-1:0];
			end
			S_EXEC: begin
				ram_en    = (cmd_q == CMD_SWAP);
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
			end
			S_WR2: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = cnt_m2[AW-1:0];
				ram_wdata = a_q;
			end
			S_WRR: begin
				ram_en   = 1'b1;
				ram_we   = 1'b1;
				ram_addr = cnt_m2[AW-1:0];
			end
			S_DUPR: begin
				ram_en   = 1'b1;
				ram_addr = src_q;
			end
			S_DUPW: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = dst_q;
				ram_wdata = ram_rdata;
			end
			default: ram_en = 1'b0;
		endcase
	end

	// divider launch
	assign div_req.start    = (state_q == S_EXEC) && (ram_rdata != '0) &&
		((cmd_q == CMD_DIV) || (cmd_q == CMD_MOD));
	assign div_req.dividend = a_q;
	assign div_req.divisor  = ram_rdata;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			pc_q      <= '0;
			m_valid_q <= 1'b0;
			cmd_q     <= CMD_IN;
			st_q      <= ST_OK;
			ov_q      <= 1'b0;
		end else begin
			if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q   <= in_cmd;
						jt_q    <= jt;
						npc_q   <= npc_inc;
						ov_q    <= 1'b0;
						oval_q  <= '0;
						st_q    <= ST_OK;
						state_q <= S_DONE;
						unique case (in_cmd)
							CMD_IN, CMD_LIT: begin
								if (full) begin
									st_q <= ST_OVER;
								end else begin
									cnt_q <= cnt_q + 1'b1;
								end
							end
							CMD_OUT: begin
								if (cnt_q == '0) begin
									st_q <= ST_UNDER;
								end else begin
									state_q <= S_OUT;
								end
							end
							CMD_DROP: begin
								if (cnt_q == '0) begin
									st_q <= ST_UNDER;
								end else begin
									cnt_q <= cnt_m1;
								end
							end
							CMD_DUP: begin
								if (dup_pos) begin
									if (cnt_q == '0) begin
										st_q <= ST_UNDER;
									end else if (dup_sum > (CNT_W+1)'(STACK_DEPTH)) begin
										st_q <= ST_OVER;
									end else begin
										src_q   <= AW'(cnt_q - dup_m);
										dst_q   <= cnt_q[AW-1:0];
										rem_q   <= dup_m;
										dupm_q  <= dup_m;
										state_q <= S_DUPR;
									end
								end
							end
							CMD_JUMP: npc_q <= jt;
							default: begin
								if (cnt_q < CNT_W'(2)) begin
									st_q <= ST_UNDER;
								end else begin
									state_q <= S_RDB;
								end
							end
						endcase
					end
				end
				S_OUT: begin
					ov_q    <= 1'b1;
					oval_q  <= ram_rdata;
					cnt_q   <= cnt_m1;
					state_q <= S_DONE;
				end
				S_RDB: begin
					a_q     <= ram_rdata;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					unique case (cmd_q)
						CMD_SWAP: state_q <= S_WR2;
						CMD_DIV, CMD_MOD: begin
							if (ram_rdata == '0) begin
								st_q    <= ST_DIV0;
								state_q <= S_DONE;
							end else begin
								state_q <= S_DIV;
							end
						end
						CMD_IFEQ, CMD_IFLT: begin
							cnt_q   <= cnt_m2;
							state_q <= S_DONE;
							if ((cmd_q == CMD_IFEQ) ? (a_q == ram_rdata) :
								($signed(a_q) < $signed(ram_rdata))) begin
								npc_q <= jt_q;
							end
						end
						default: begin
							res_q   <= alu;
							state_q <= S_WRR;
						end
					endcase
				end
				S_DIV: begin
					if (div_done) begin
						res_q   <= (cmd_q == CMD_MOD) ? div_rem : div_quot;
						state_q <= S_WRR;
					end
				end
				S_WRR: begin
					cnt_q   <= cnt_m1;
					state_q <= S_DONE;
				end
				S_WR2: state_q <= S_DONE;
				S_DUPR: state_q <= S_DUPW;
				S_DUPW: begin
					src_q <= src_q + 1'b1;
					dst_q <= dst_q + 1'b1;
					rem_q <= rem_q - 1'b1;
					if (rem_q == CNT_W'(1)) begin
						cnt_q   <= cnt_q + dupm_q;
						state_q <= S_DONE;
					end else begin
						state_q <= S_DUPR;
					end
				end
				S_DONE: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						mv_q      <= ov_q;
						mval_q    <= oval_q;
						mpc_q     <= npc_q;
						mst_q     <= st_q;
						pc_q      <= npc_q;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output stream
	assign m_tvalid = m_valid_q;
	assign m_tdata  = MW'({mst_q, mpc_q, mval_q, mv_q});

	smx_stack_ram #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	smx_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

endmodule

`default_nettype wire

/* rtl/smx_checker.sv */
// ----------------------------------------------------------------------------
// smx_checker
// Port-level checks on the stack machine execute block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stack_machine_execute_top_assert.svh"

module smx_checker #(
	parameter int PROG_DEPTH = 1024,
	localparam int PC_W = $clog2(PROG_DEPTH + 1),
	localparam int MW   = ((35 + PC_W + 7) / 8) * 8
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          m_tvalid,
	input wire logic          m_tready,
	input wire logic [MW-1:0] m_tdata
);
	logic          mv;
	logic [31:0]   mval;
	logic [PC_W-1:0] mpc;
	logic [1:0]    mst;

	assign mv   = m_tdata[0];
	assign mval = m_tdata[32:1];
	assign mpc  = m_tdata[32+PC_W:33];
	assign mst  = m_tdata[34+PC_W:33+PC_W];

	// stalled result holds
	`SMX_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// a popped word never comes with a fault
	`SMX_ASSERT_IMP(a_out_ok, m_tvalid && mv, mst == 2'd0)
	// no popped word means a zero value
	`SMX_ASSERT_IMP(a_out_zero, m_tvalid && !mv, mval == 32'd0)
	// next pc never passes the halt index
	`SMX_ASSERT_IMP(a_pc_range, m_tvalid, mpc <= PC_W'(PROG_DEPTH))

endmodule

bind stack_machine_execute_top smx_checker #(.PROG_DEPTH(PROG_DEPTH)) u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
